### hdl/fca_pkg.sv
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types and constants of the block allocation table: command codes,
// result status codes, controller states and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fca_pkg;

   // Field widths of one transaction on either stream.
   localparam int OP_W       = 3;
   localparam int BLOCK_W    = 12;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // Command codes carried in the request.
   typedef enum logic [OP_W-1:0] {
      OP_BEGIN  = 3'd0,
      OP_EXTEND = 3'd1,
      OP_FINISH = 3'd2,
      OP_FREE   = 3'd3,
      OP_NEXT   = 3'd4,
      OP_FORMAT = 3'd5
   } op_type;

   // Status codes carried in the response.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_BAD      = 2'd2,
      ST_NO_CHAIN = 2'd3
   } status_type;

   // Source of the block field of a response.
   typedef enum logic [2:0] {
      RES_ZERO      = 3'd0,
      RES_CUR       = 3'd1,
      RES_TAIL      = 3'd2,
      RES_COUNT     = 3'd3,
      RES_COUNT_INC = 3'd4,
      RES_LINK      = 3'd5
   } res_sel_type;

   // Controller states.
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CK,
      S_WR_END,
      S_WALK_RD,
      S_WALK_CK,
      S_NEXT_RD,
      S_NEXT_CK,
      S_RESP
   } state_type;

   // Commands from the controller to the datapath, one cycle each.
   typedef struct packed {
      logic        clr_start;     // restart the clearing sweep at entry 0
      logic        clr_step;      // write one clearing entry and advance
      logic        cur_one;       // cursor <= 1
      logic        cur_tail_inc;  // cursor <= tail + 1
      logic        cur_blk;       // cursor <= requested block
      logic        cur_inc;       // cursor <= cursor + 1
      logic        cur_link;      // cursor <= link just read
      logic        wr_tail_link;  // table[tail] <= cursor
      logic        wr_tail_end;   // table[tail] <= end marker
      logic        wr_cur_end;    // table[cursor] <= end marker
      logic        wr_cur_free;   // table[cursor] <= free, count one more
      logic        set_tail_open; // tail <= cursor, chain open
      logic        drop_open;     // chain closed
      logic        reset_chain;   // tail <= 0, chain closed
      logic        count_clr;     // freed count <= 0
      logic        res_load;      // capture a response
      res_sel_type res_sel;
      logic        res_end;
      status_type  res_st;
      logic        out_load;      // move the response to the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rd_free;     // entry read is free
      logic rd_end;      // entry read is the end marker
      logic cur_last;    // cursor is the highest block
      logic tail_last;   // tail is the highest block
      logic chain_open;  // a chain is open
      logic blk_bad;     // requested block is zero or out of range
      logic clr_last;    // clearing sweep is at the highest block
      logic out_ready;   // output register can take a response
   } sts_type;

endpackage

### hdl/fat_chain_allocator_top.sv
// Begin and extend scan the table for a free block; finish, spare codes and
// commands rejected at once go straight to the response. Free walks the
// chain entry by entry and next reads one entry. Format sweeps the table one
// entry a cycle, then responds.
// One command is in work at a time; the next is taken once its response is in
// the output register. After reset the same sweep runs before any request.
// ----------------------------------------------------------------------------
// fat_chain_allocator_top
// Block allocation table with chain commands: begin, extend, finish, free,
// next and format, one request transaction giving one response transaction.
// ----------------------------------------------------------------------------
module fat_chain_allocator_top
   import fca_pkg::*;
#(
   parameter int BLOCKS = 4096
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [2:0] operation, [14:3] block
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [11:0] block_out, [12] at_end,
                                              // [14:13] status
);

   cmd_type             cmd;
   sts_type             sts;
   logic [BLOCK_W-1:0]  rsp_block;
   logic                rsp_at_end;
   logic [STATUS_W-1:0] rsp_status;

   // Sequencer.
   fca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tdata[OP_W-1:0]),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Table and response path.
   fca_datapath #(
      .BLOCKS (BLOCKS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_block  (req_tdata[OP_W+BLOCK_W-1:OP_W]),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_block  (rsp_block),
      .rsp_at_end (rsp_at_end),
      .rsp_status (rsp_status)
   );

   // Pack the response fields, lowest first.
   assign rsp_tdata = {1'b0, rsp_status, rsp_at_end, rsp_block};

endmodule

### hdl/fca_ctrl.sv
// ----------------------------------------------------------------------------
// fca_ctrl
// Sequencer of the allocation table: accepts one command, steps the datapath
// through table scans, chain walks and clearing sweeps, then hands the
// response to the output register.
// ----------------------------------------------------------------------------
module fca_ctrl
   import fca_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [OP_W-1:0]    req_op,
   input  sts_type            sts,
   output cmd_type            cmd
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      pending_ff, pending_in;  // a format response follows the sweep
   logic      first_ff, first_in;      // first entry of a free walk
   logic      accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         op_ff      <= OP_BEGIN;
         pending_ff <= 1'b0;
         first_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         op_ff      <= op_in;
         pending_ff <= pending_in;
         first_ff   <= first_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      pending_in = pending_ff;
      first_in   = first_ff;
      cmd        = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               pending_in = 1'b0;
               state_in   = pending_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in = op_type'(req_op);
               case (req_op)
                  OP_BEGIN: begin
                     cmd.cur_one = 1'b1;
                     state_in    = S_SCAN_RD;
                  end
                  OP_EXTEND: begin
                     if (!sts.chain_open) begin
                        cmd.res_load = 1'b1;
                        cmd.res_st   = ST_NO_CHAIN;
                        state_in     = S_RESP;
                     end else if (sts.tail_last) begin
                        cmd.wr_tail_end = 1'b1;
                        cmd.drop_open   = 1'b1;
                        cmd.res_load    = 1'b1;
                        cmd.res_st      = ST_FULL;
                        state_in        = S_RESP;
                     end else begin
                        cmd.cur_tail_inc = 1'b1;
                        state_in         = S_SCAN_RD;
                     end
                  end
                  OP_FINISH: begin
                     cmd.res_load = 1'b1;
                     if (!sts.chain_open) begin
                        cmd.res_st = ST_NO_CHAIN;
                     end else begin
                        cmd.wr_tail_end = 1'b1;
                        cmd.drop_open   = 1'b1;
                        cmd.res_sel     = RES_TAIL;
                     end
                     state_in = S_RESP;
                  end
                  OP_FREE: begin
                     if (sts.blk_bad) begin
                        cmd.res_load = 1'b1;
                        cmd.res_st   = ST_BAD;
                        state_in     = S_RESP;
                     end else begin
                        cmd.cur_blk   = 1'b1;
                        cmd.count_clr = 1'b1;
                        first_in      = 1'b1;
                        state_in      = S_WALK_RD;
                     end
                  end
                  OP_NEXT: begin
                     if (sts.blk_bad) begin
                        cmd.res_load = 1'b1;
                        cmd.res_st   = ST_BAD;
                        state_in     = S_RESP;
                     end else begin
                        cmd.cur_blk = 1'b1;
                        state_in    = S_NEXT_RD;
                     end
                  end
                  OP_FORMAT: begin
                     cmd.clr_start   = 1'b1;
                     cmd.reset_chain = 1'b1;
                     cmd.res_load    = 1'b1;
                     pending_in      = 1'b1;
                     state_in        = S_CLEAR;
                  end
                  default: begin
                     cmd.res_load = 1'b1;
                     state_in     = S_RESP;
                  end
               endcase
            end
         end
         // The table read is issued here and checked in the next cycle.
         S_SCAN_RD: state_in = S_SCAN_CK;
         S_SCAN_CK: begin
            if (sts.rd_free) begin
               cmd.wr_tail_link = (op_ff == OP_EXTEND);
               state_in         = S_WR_END;
            end else if (sts.cur_last) begin
               cmd.wr_tail_end = (op_ff == OP_EXTEND);
               cmd.drop_open   = 1'b1;
               cmd.res_load    = 1'b1;
               cmd.res_st      = ST_FULL;
               state_in        = S_RESP;
            end else begin
               cmd.cur_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_WR_END: begin
            cmd.wr_cur_end    = 1'b1;
            cmd.set_tail_open = 1'b1;
            cmd.res_load      = 1'b1;
            cmd.res_sel       = RES_CUR;
            state_in          = S_RESP;
         end
         S_WALK_RD: state_in = S_WALK_CK;
         S_WALK_CK: begin
            first_in = 1'b0;
            if (sts.rd_free) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_COUNT;
               cmd.res_st   = first_ff ? ST_BAD : ST_OK;
               state_in     = S_RESP;
            end else begin
               cmd.wr_cur_free = 1'b1;
               if (sts.rd_end) begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RES_COUNT_INC;
                  state_in     = S_RESP;
               end else begin
                  cmd.cur_link = 1'b1;
                  state_in     = S_WALK_RD;
               end
            end
         end
         S_NEXT_RD: state_in = S_NEXT_CK;
         S_NEXT_CK: begin
            cmd.res_load = 1'b1;
            if (sts.rd_free) begin
               cmd.res_st = ST_BAD;
            end else if (sts.rd_end) begin
               cmd.res_end = 1'b1;
            end else begin
               cmd.res_sel = RES_LINK;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (sts.out_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

endmodule

### hdl/fca_datapath.sv
// ----------------------------------------------------------------------------
// fca_datapath
// Link table memory with its cursor, open-chain tail, freed-block counter,
// response capture and the output register of the response stream.
// ----------------------------------------------------------------------------
module fca_datapath
   import fca_pkg::*;
#(
   parameter int BLOCKS = 4096
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic [BLOCK_W-1:0]  req_block,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [BLOCK_W-1:0]  rsp_block,
   output logic                rsp_at_end,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int AW = $clog2(BLOCKS);
   localparam int EW = $clog2(BLOCKS + 1);
   localparam logic [EW-1:0] END_VAL  = EW'(BLOCKS);
   localparam logic [AW-1:0] LAST_IDX = AW'(BLOCKS - 1);

   logic [EW-1:0] link_mem [BLOCKS];
   logic [EW-1:0] rd_data_ff;

   logic [AW-1:0]      cursor_ff, cursor_in;
   logic [AW-1:0]      tail_ff, tail_in;
   logic               open_ff, open_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [BLOCK_W-1:0] count_ff, count_in;

   logic [BLOCK_W-1:0] res_block_ff;
   logic               res_end_ff;
   status_type         res_st_ff;
   logic [BLOCK_W-1:0] res_value;

   logic               out_valid_ff;
   logic [BLOCK_W-1:0] out_block_ff;
   logic               out_end_ff;
   status_type         out_st_ff;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [EW-1:0]      wr_data;

   logic [31:0] blk32, cur32, tail32, rd32;

   assign blk32  = {{(32-BLOCK_W){1'b0}}, req_block};
   assign cur32  = 32'(cursor_ff);
   assign tail32 = 32'(tail_ff);
   assign rd32   = 32'(rd_data_ff);

   // Status towards the controller.
   always_comb begin
      sts.rd_free    = (rd_data_ff == '0);
      sts.rd_end     = (rd_data_ff == END_VAL);
      sts.cur_last   = (cursor_ff == LAST_IDX);
      sts.tail_last  = (tail_ff == LAST_IDX);
      sts.chain_open = open_ff;
      sts.blk_bad    = (req_block == '0) || (blk32 >= 32'(BLOCKS));
      sts.clr_last   = (clr_ff == LAST_IDX);
      sts.out_ready  = !out_valid_ff || rsp_tready;
   end

   // Single write port of the table; the controller raises at most one request a cycle.
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = cursor_ff;
      wr_data = '0;
      if (cmd.clr_step) begin
         wr_addr = clr_ff;
         wr_data = (clr_ff == '0) ? END_VAL : '0;
      end else if (cmd.wr_tail_link) begin
         wr_addr = tail_ff;
         wr_data = cur32[EW-1:0];
      end else if (cmd.wr_tail_end) begin
         wr_addr = tail_ff;
         wr_data = END_VAL;
      end else if (cmd.wr_cur_end) begin
         wr_data = END_VAL;
      end else if (cmd.wr_cur_free) begin
         wr_data = '0;
      end else begin
         wr_en = 1'b0;
      end
   end

   // Table memory with a registered read at the cursor.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= link_mem[cursor_ff];
   end

   // Next values of cursor, tail, chain flag, sweep address and counter.
   always_comb begin
      cursor_in = cursor_ff;
      if (cmd.cur_one) begin
         cursor_in = AW'(1);
      end else if (cmd.cur_tail_inc) begin
         cursor_in = tail_ff + AW'(1);
      end else if (cmd.cur_blk) begin
         cursor_in = blk32[AW-1:0];
      end else if (cmd.cur_inc) begin
         cursor_in = cursor_ff + AW'(1);
      end else if (cmd.cur_link) begin
         cursor_in = rd32[AW-1:0];
      end

      tail_in = tail_ff;
      open_in = open_ff;
      if (cmd.reset_chain) begin
         tail_in = '0;
         open_in = 1'b0;
      end else if (cmd.set_tail_open) begin
         tail_in = cursor_ff;
         open_in = 1'b1;
      end else if (cmd.drop_open) begin
         open_in = 1'b0;
      end else if (cmd.wr_cur_free && (cursor_ff == tail_ff)) begin
         // Freeing the open tail drops the open chain.
         open_in = 1'b0;
      end

      clr_in = clr_ff;
      if (cmd.clr_start) begin
         clr_in = '0;
      end else if (cmd.clr_step) begin
         clr_in = clr_ff + AW'(1);
      end

      count_in = count_ff;
      if (cmd.count_clr) begin
         count_in = '0;
      end else if (cmd.wr_cur_free) begin
         count_in = count_ff + BLOCK_W'(1);
      end
   end

   // Control registers of the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff <= '0;
         open_ff <= 1'b0;
         clr_ff  <= '0;
      end else begin
         tail_ff <= tail_in;
         open_ff <= open_in;
         clr_ff  <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      count_ff  <= count_in;
   end

   // Block field of the response being captured.
   always_comb begin
      case (cmd.res_sel)
         RES_ZERO:      res_value = '0;
         RES_CUR:       res_value = cur32[BLOCK_W-1:0];
         RES_TAIL:      res_value = tail32[BLOCK_W-1:0];
         RES_COUNT:     res_value = count_ff;
         RES_COUNT_INC: res_value = count_ff + BLOCK_W'(1);
         RES_LINK:      res_value = rd32[BLOCK_W-1:0];
         default:       res_value = '0;
      endcase
   end

   // Response capture and output register.
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_block_ff <= res_value;
         res_end_ff   <= cmd.res_end;
         res_st_ff    <= cmd.res_st;
      end
      if (cmd.out_load) begin
         out_block_ff <= res_block_ff;
         out_end_ff   <= res_end_ff;
         out_st_ff    <= res_st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_block  = out_block_ff;
   assign rsp_at_end = out_end_ff;
   assign rsp_status = out_st_ff;

endmodule
